// ===== hdl/sts_pkg.sv =====
// Shared types, token codes and keyword table of the SQL token scanner.
package sts_pkg;

  localparam int NREC    = 5;    // most records one text byte can cause
  localparam int NUM_KW  = 63;
  localparam int KW_BITS = 128;  // keyword text, right aligned, up to 16 bytes

  typedef logic [6:0] kind_t;

  localparam kind_t K_IDENT   = 7'd63;
  localparam kind_t K_INTEGER = 7'd64;
  localparam kind_t K_REAL    = 7'd65;
  localparam kind_t K_STRING  = 7'd66;
  localparam kind_t K_PLUS    = 7'd67;
  localparam kind_t K_MINUS   = 7'd68;
  localparam kind_t K_STAR    = 7'd69;
  localparam kind_t K_SLASH   = 7'd70;
  localparam kind_t K_PCT     = 7'd71;
  localparam kind_t K_EQ      = 7'd72;
  localparam kind_t K_NE      = 7'd73;
  localparam kind_t K_LT      = 7'd74;
  localparam kind_t K_LE      = 7'd75;
  localparam kind_t K_GT      = 7'd76;
  localparam kind_t K_GE      = 7'd77;
  localparam kind_t K_SEMI    = 7'd78;
  localparam kind_t K_COMMA   = 7'd79;
  localparam kind_t K_LPAR    = 7'd80;
  localparam kind_t K_RPAR    = 7'd81;
  localparam kind_t K_DOT     = 7'd82;
  localparam kind_t K_END     = 7'd83;
  localparam kind_t K_ERROR   = 7'd84;
  localparam kind_t K_NONE    = 7'd0;

  typedef enum logic [1:0] {
    E_NONE  = 2'd0,
    E_CHAR  = 2'd1,
    E_BANG  = 2'd2,
    E_UNTRM = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_STR, M_STR_ESC,
    M_LT, M_GT, M_BANG, M_DEAD, M_DONE
  } mode_t;

  typedef struct packed {
    logic       is_value_byte;
    logic [7:0] value_byte;
    kind_t      token_kind;
    err_t       error_code;
  } rec_t;

  localparam logic [KW_BITS-1:0] KW_TAB [NUM_KW] = '{
    "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "UPDATE", "SET",
    "DELETE", "CREATE", "TABLE", "DROP", "ALTER", "INDEX", "PRIMARY", "KEY",
    "FOREIGN", "REFERENCES", "AND", "OR", "NOT", "NULL", "TRUE", "FALSE",
    "DISTINCT", "ORDER", "BY", "GROUP", "HAVING", "LIMIT", "OFFSET", "JOIN",
    "INNER", "LEFT", "RIGHT", "OUTER", "ON", "UNION", "INTERSECT", "EXCEPT",
    "AS", "CASE", "WHEN", "THEN", "ELSE", "END", "IF", "EXISTS", "BEGIN",
    "COMMIT", "ROLLBACK", "TRANSACTION", "VACUUM", "ANALYZE", "INT",
    "VARCHAR", "CHAR", "TEXT", "REAL", "BOOLEAN", "DATE", "TIME", "TIMESTAMP"
  };

  // parallel compare against every keyword
  function automatic kind_t kw_find(input logic [KW_BITS-1:0] w);
    kind_t k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (w == KW_TAB[i]) k = 7'(i);
    end
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
  endfunction

  function automatic kind_t single_op(input logic [7:0] c);
    kind_t k;
    case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "%":     k = K_PCT;
      "=":     k = K_EQ;
      ";":     k = K_SEMI;
      ",":     k = K_COMMA;
      "(":     k = K_LPAR;
      ")":     k = K_RPAR;
      ".":     k = K_DOT;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic rec_t mk_val(input logic [7:0] b);
    return '{is_value_byte: 1'b1, value_byte: b, token_kind: K_NONE, error_code: E_NONE};
  endfunction

  function automatic rec_t mk_tok(input kind_t k);
    return '{is_value_byte: 1'b0, value_byte: 8'd0, token_kind: k, error_code: E_NONE};
  endfunction

  function automatic rec_t mk_err(input err_t e);
    return '{is_value_byte: 1'b0, value_byte: 8'd0, token_kind: K_ERROR, error_code: e};
  endfunction

endpackage

// ===== hdl/sts_front.sv =====
// Scanner front end: classifies each byte and builds the records it causes.
module sts_front #(
  parameter int KEYWORD_MAX_LEN = 11,
  parameter int POSITION_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc_i,
  input  logic [7:0]               text_byte_i,
  input  logic                     final_byte_i,
  output sts_pkg::rec_t            recs_o [sts_pkg::NREC],
  output logic [POSITION_BITS-1:0] lines_o [sts_pkg::NREC],
  output logic [POSITION_BITS-1:0] cols_o [sts_pkg::NREC],
  output logic [2:0]               cnt_o
);
  import sts_pkg::*;

  localparam int P   = POSITION_BITS;
  localparam int WB  = KEYWORD_MAX_LEN * 8;
  localparam int WLW = $clog2(KEYWORD_MAX_LEN + 2);

  mode_t          mode_r, mode_nxt;
  logic           dq_r, dq_nxt;
  logic [WB-1:0]  word_r, word_nxt;
  logic [WLW-1:0] wlen_r, wlen_nxt;
  logic [P-1:0]   line_r, line_nxt, col_r, col_nxt;
  logic [P-1:0]   tline_r, tline_nxt, tcol_r, tcol_nxt, dcol_r, dcol_nxt;

  function automatic logic [P-1:0] inc_sat(input logic [P-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic kind_t word_kind(input logic [WB-1:0] w, input logic [WLW-1:0] l);
    return (l > WLW'(KEYWORD_MAX_LEN)) ? K_IDENT : kw_find(KW_BITS'(w));
  endfunction

  always_comb begin
    mode_t        m;
    logic [7:0]   b;
    logic         fall;
    kind_t        k;
    logic [2:0]   n;
    m    = mode_r;
    b    = text_byte_i;
    fall = 1'b0;
    k    = K_NONE;
    n    = 3'd0;
    dq_nxt = dq_r; word_nxt = word_r; wlen_nxt = wlen_r;
    line_nxt = line_r; col_nxt = col_r; tline_nxt = tline_r; tcol_nxt = tcol_r;
    dcol_nxt = dcol_r;
    for (int i = 0; i < NREC; i++) begin
      recs_o[i] = mk_tok(K_NONE);
      lines_o[i] = '0;
      cols_o[i]  = '0;
    end

    if (m != M_DEAD && m != M_DONE) begin
      unique case (m) inside
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            if (wlen_nxt < WLW'(KEYWORD_MAX_LEN)) begin
              word_nxt = {word_nxt[WB-9:0], to_upper(b)};
              wlen_nxt = wlen_nxt + 1'b1;
            end else if (wlen_nxt == WLW'(KEYWORD_MAX_LEN)) begin
              wlen_nxt = wlen_nxt + 1'b1;
            end
            recs_o[n] = mk_val(b); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
          end else begin
            recs_o[n] = mk_tok(word_kind(word_nxt, wlen_nxt));
            lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            fall = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (is_digit(b)) begin
            recs_o[n] = mk_val(b); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
          end else if (m == M_INT && b == ".") begin
            dcol_nxt = col_nxt;
            m = M_INT_DOT;
          end else begin
            recs_o[n] = mk_tok((m == M_INT) ? K_INTEGER : K_REAL);
            lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            fall = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(b)) begin
            recs_o[n] = mk_val("."); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            recs_o[n] = mk_val(b); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            m = M_FRAC;
          end else begin
            recs_o[n] = mk_tok(K_INTEGER); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt;
            n = n + 1'b1;
            recs_o[n] = mk_tok(K_DOT); lines_o[n] = line_nxt; cols_o[n] = dcol_nxt;
            n = n + 1'b1;
            fall = 1'b1;
          end
        end
        M_STR: begin
          if (b == (dq_nxt ? 8'h22 : 8'h27)) begin
            recs_o[n] = mk_tok(K_STRING); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt;
            n = n + 1'b1;
            m = M_IDLE;
          end else if (b == 8'h0a) begin
            recs_o[n] = mk_err(E_UNTRM); lines_o[n] = line_nxt; cols_o[n] = col_nxt;
            n = n + 1'b1;
            m = M_DEAD;
          end else if (b == 8'h5c) begin
            m = M_STR_ESC;
          end else begin
            recs_o[n] = mk_val(b); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
          end
        end
        M_STR_ESC: begin
          recs_o[n] = mk_val((b == "n") ? 8'h0a : (b == "t") ? 8'h09 : (b == "r") ? 8'h0d : b);
          lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
          m = M_STR;
        end
        M_LT, M_GT, M_BANG: begin
          if (b == "=" || (m == M_LT && b == ">")) begin
            if (m == M_LT && b == "=")      k = K_LE;
            else if (m == M_GT)             k = K_GE;
            else                            k = K_NE;
            recs_o[n] = mk_tok(k); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            m = M_IDLE;
          end else if (m == M_BANG) begin
            recs_o[n] = mk_err(E_BANG); lines_o[n] = line_nxt; cols_o[n] = col_nxt;
            n = n + 1'b1;
            m = M_DEAD;
          end else begin
            recs_o[n] = mk_tok((m == M_LT) ? K_LT : K_GT);
            lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            fall = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase

      // byte starts something new (or is skipped)
      if (fall) begin
        m = M_IDLE;
        if (!(b inside {8'h20, 8'h0d, 8'h09, 8'h0a})) begin
          tline_nxt = line_nxt;
          tcol_nxt  = col_nxt;
          k = single_op(b);
          if (b == 8'h27 || b == 8'h22) begin
            dq_nxt = (b == 8'h22);
            m = M_STR;
          end else if (is_digit(b)) begin
            recs_o[n] = mk_val(b); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            m = M_INT;
          end else if (is_alpha(b)) begin
            word_nxt = WB'(to_upper(b));
            wlen_nxt = WLW'(1);
            recs_o[n] = mk_val(b); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
            m = M_IDENT;
          end else if (k != K_NONE) begin
            recs_o[n] = mk_tok(k); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
          end else if (b == "<") begin
            m = M_LT;
          end else if (b == ">") begin
            m = M_GT;
          end else if (b == "!") begin
            m = M_BANG;
          end
        end
      end

      // position moves on unless the byte was left for a later step
      if (!(mode_r == M_STR && b == 8'h0a) && !(mode_r == M_BANG && m == M_DEAD)) begin
        if (b == 8'h0a) begin
          line_nxt = inc_sat(line_nxt);
          col_nxt  = P'(1);
        end else begin
          col_nxt = inc_sat(col_nxt);
        end
      end

      // unexpected character: reported after the byte's step
      if (fall && m == M_IDLE && !(b inside {8'h20, 8'h0d, 8'h09, 8'h0a})
          && !is_alpha(b) && !is_digit(b) && single_op(b) == K_NONE) begin
        recs_o[n] = mk_err(E_CHAR); lines_o[n] = line_nxt; cols_o[n] = col_nxt; n = n + 1'b1;
        m = M_DEAD;
      end

      // end of text
      if (final_byte_i && m != M_DEAD) begin
        unique case (m) inside
          M_IDENT: begin
            recs_o[n] = mk_tok(word_kind(word_nxt, wlen_nxt));
            lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
          end
          M_INT, M_FRAC, M_LT, M_GT: begin
            if (m == M_INT)      k = K_INTEGER;
            else if (m == M_FRAC) k = K_REAL;
            else if (m == M_LT)   k = K_LT;
            else                  k = K_GT;
            recs_o[n] = mk_tok(k); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt; n = n + 1'b1;
          end
          M_INT_DOT: begin
            recs_o[n] = mk_tok(K_INTEGER); lines_o[n] = tline_nxt; cols_o[n] = tcol_nxt;
            n = n + 1'b1;
            recs_o[n] = mk_tok(K_DOT); lines_o[n] = line_nxt; cols_o[n] = dcol_nxt;
            n = n + 1'b1;
          end
          M_STR, M_STR_ESC, M_BANG: begin
            recs_o[n] = mk_err((m == M_BANG) ? E_BANG : E_UNTRM);
            lines_o[n] = line_nxt; cols_o[n] = col_nxt; n = n + 1'b1;
            m = M_DEAD;
          end
          default: ;
        endcase
        if (m != M_DEAD) begin
          recs_o[n] = mk_tok(K_END); lines_o[n] = line_nxt; cols_o[n] = col_nxt; n = n + 1'b1;
          m = M_DONE;
        end
      end
    end
    mode_nxt = m;
    cnt_o    = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      dq_r    <= 1'b0;
      wlen_r  <= '0;
      line_r  <= P'(1);
      col_r   <= P'(1);
      tline_r <= P'(1);
      tcol_r  <= P'(1);
      dcol_r  <= P'(1);
    end else if (acc_i) begin
      mode_r  <= mode_nxt;
      dq_r    <= dq_nxt;
      wlen_r  <= wlen_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      dcol_r  <= dcol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i) word_r <= word_nxt;
  end

endmodule

// ===== hdl/sts_queue.sv =====
// Short queue of per-byte record groups between front and back.
module sts_queue #(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_i,
  input  sts_pkg::rec_t            recs_i [sts_pkg::NREC],
  input  logic [POSITION_BITS-1:0] lines_i [sts_pkg::NREC],
  input  logic [POSITION_BITS-1:0] cols_i [sts_pkg::NREC],
  input  logic [2:0]               cnt_i,
  input  logic                     pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output sts_pkg::rec_t            recs_o [sts_pkg::NREC],
  output logic [POSITION_BITS-1:0] lines_o [sts_pkg::NREC],
  output logic [POSITION_BITS-1:0] cols_o [sts_pkg::NREC],
  output logic [2:0]               cnt_o
);
  import sts_pkg::*;

  localparam int QD = 4;

  rec_t                     rec_q  [QD][NREC];
  logic [POSITION_BITS-1:0] line_q [QD][NREC];
  logic [POSITION_BITS-1:0] col_q  [QD][NREC];
  logic [2:0]               cnt_q  [QD];
  logic [1:0]               wp_r, rp_r;
  logic [2:0]               used_r;

  assign full_o  = (used_r == 3'(QD));
  assign empty_o = (used_r == 3'd0);

  always_comb begin
    recs_o  = rec_q[rp_r];
    lines_o = line_q[rp_r];
    cols_o  = col_q[rp_r];
    cnt_o   = cnt_q[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      used_r <= '0;
    end else begin
      if (push_i) wp_r <= wp_r + 1'b1;
      if (pop_i)  rp_r <= rp_r + 1'b1;
      used_r <= used_r + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      rec_q[wp_r]  <= recs_i;
      line_q[wp_r] <= lines_i;
      col_q[wp_r]  <= cols_i;
      cnt_q[wp_r]  <= cnt_i;
    end
  end

endmodule

// ===== hdl/sts_back.sv =====
// Back end: hands out the head group's records one beat at a time.
module sts_back #(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty_i,
  input  sts_pkg::rec_t            recs_i [sts_pkg::NREC],
  input  logic [POSITION_BITS-1:0] lines_i [sts_pkg::NREC],
  input  logic [POSITION_BITS-1:0] cols_i [sts_pkg::NREC],
  input  logic [2:0]               cnt_i,
  input  logic                     pop_i,
  output logic                     q_pop_o,
  output logic [2:0]               idx_o,
  output sts_pkg::rec_t            rec_o,
  output logic [POSITION_BITS-1:0] line_o,
  output logic [POSITION_BITS-1:0] col_o,
  output logic                     last_o
);
  import sts_pkg::*;

  logic [2:0] idx_r;

  assign idx_o   = idx_r;
  assign rec_o   = recs_i[idx_r];
  assign line_o  = lines_i[idx_r];
  assign col_o   = cols_i[idx_r];
  assign last_o  = (idx_r == cnt_i - 3'd1);
  assign q_pop_o = pop_i && !q_empty_i && last_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (pop_i && !q_empty_i) begin
      idx_r <= last_o ? 3'd0 : idx_r + 3'd1;
    end
  end

endmodule

// ===== hdl/sql_token_scanner.sv =====
// Top level of the SQL token scanner: front end, record queue, back end.
//
//   channel | direction | handshake       | beat
//   in_     | in        | in_push/in_full | one text byte, last-byte flag
//   out_    | out       | out_pop/out_empty | one value or token record
//
// One text byte is taken per cycle while in_full is low; the front end
// decodes it in the same cycle (keyword match is a parallel compare against
// all 63 keywords) and queues the one to five records it causes as one
// group; a byte with no record (whitespace, open quotes) queues nothing.
// Records leave at one per cycle while out_pop is high and out_empty is low.
// Four groups fit in the queue; in_full rises only when it is full.
// Reset is synchronous; the scanner restarts at line 1, column 1.
// After an end or error record, bytes are still taken but ignored.
module sql_token_scanner #(
  parameter int KEYWORD_MAX_LEN = 11,
  parameter int POSITION_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [7:0]               in_text_byte,
  input  logic                     in_final_byte,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_is_value_byte,
  output logic [7:0]               out_value_byte,
  output logic [6:0]               out_token_kind,
  output logic [1:0]               out_error_code,
  output logic [POSITION_BITS-1:0] out_tok_line,
  output logic [POSITION_BITS-1:0] out_tok_col,
  output logic                     out_last
);
  import sts_pkg::*;

  localparam int P = POSITION_BITS;

  logic         acc, q_push, q_pop, q_full, q_empty;
  rec_t         f_recs [NREC];
  logic [P-1:0] f_lines [NREC];
  logic [P-1:0] f_cols [NREC];
  logic [2:0]   f_cnt;
  rec_t         h_recs [NREC];
  logic [P-1:0] h_lines [NREC];
  logic [P-1:0] h_cols [NREC];
  logic [2:0]   h_cnt, b_idx;
  rec_t         o_rec;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;
  // only groups that hold records enter the queue
  assign q_push  = acc && (f_cnt != 3'd0);

  sts_front #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
    .POSITION_BITS   (POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_i        (acc),
    .text_byte_i  (in_text_byte),
    .final_byte_i (in_final_byte),
    .recs_o       (f_recs),
    .lines_o      (f_lines),
    .cols_o       (f_cols),
    .cnt_o        (f_cnt)
  );

  sts_queue #(.POSITION_BITS(POSITION_BITS)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .recs_i  (f_recs),
    .lines_i (f_lines),
    .cols_i  (f_cols),
    .cnt_i   (f_cnt),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .recs_o  (h_recs),
    .lines_o (h_lines),
    .cols_o  (h_cols),
    .cnt_o   (h_cnt)
  );

  sts_back #(.POSITION_BITS(POSITION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty_i (q_empty),
    .recs_i    (h_recs),
    .lines_i   (h_lines),
    .cols_i    (h_cols),
    .cnt_i     (h_cnt),
    .pop_i     (out_pop),
    .q_pop_o   (q_pop),
    .idx_o     (b_idx),
    .rec_o     (o_rec),
    .line_o    (out_tok_line),
    .col_o     (out_tok_col),
    .last_o    (out_last)
  );

  assign out_empty         = q_empty;
  assign out_is_value_byte = o_rec.is_value_byte;
  assign out_value_byte    = o_rec.value_byte;
  assign out_token_kind    = o_rec.token_kind;
  assign out_error_code    = o_rec.error_code;

`ifndef ASSERT_OFF
  // a queued group holds between one and five records
  a_grp_size: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (f_cnt != 3'd0) && (f_cnt <= 3'(NREC)))
    else $error("record group size out of range");

  // the back end never points past the head group
  a_idx_rng: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (b_idx < h_cnt))
    else $error("record index past group end");

  // a group leaves only on its last record's beat
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> out_pop && out_last && !q_empty)
    else $error("group popped before its last record");

  // nothing waits right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("records present after reset");
`endif

endmodule
